FILE: rtl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg: shared definitions of the first-fit segment allocator
// Status codes, register indexes, reset values and controller/datapath types.
// ----------------------------------------------------------------------------
package ffsa_pkg;

	localparam int FREE_ENTRIES_DEF  = 64;
	localparam int ALLOC_ENTRIES_DEF = 64;

	// Configuration register indexes.
	localparam logic REG_REGION_SIZE = 1'b0;
	localparam logic REG_ALIGN_SHIFT = 1'b1;

	localparam logic [31:0] REGION_SIZE_RST = 32'd67108864;
	localparam logic [4:0]  ALIGN_SHIFT_RST = 5'd8;
	localparam logic [4:0]  ALIGN_SHIFT_MAX = 5'd16;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NOFIT    = 3'd1,
		ST_UNKNOWN  = 3'd2,
		ST_FULL     = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the accepted item and compute its aligned size
		logic rd_en;   // read both tables at the scan index
		logic commit;  // apply the table updates and load the result
	} ffsa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_busy;  // a result is held and not taken this cycle
		logic out_valid; // a result is held
	} ffsa_sts_t;

endpackage

FILE: rtl/ffsa_ram.sv
// ----------------------------------------------------------------------------
// ffsa_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ffsa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/ffsa_ctrl.sv
// ----------------------------------------------------------------------------
// ffsa_ctrl: allocator controller
// Sequences accept, table scan, drain of the read pipeline and commit.
// ----------------------------------------------------------------------------
module ffsa_ctrl
	import ffsa_pkg::*;
#(
	parameter int FREE_ENTRIES  = FREE_ENTRIES_DEF,
	parameter int ALLOC_ENTRIES = ALLOC_ENTRIES_DEF,
	localparam int DEPTH = (FREE_ENTRIES > ALLOC_ENTRIES) ? FREE_ENTRIES : ALLOC_ENTRIES,
	localparam int IW    = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  ffsa_sts_t       sts,
	output ffsa_cmd_t       cmd_o,
	output logic [IW-1:0]   rd_idx
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_WRITE = 4'b1000
	} state_t;

	state_t        state_q, state_d;
	logic [IW-1:0] cnt_q;

	assign in_stall = (state_q != S_IDLE);
	assign rd_idx   = cnt_q;

	always_comb begin
		state_d      = state_q;
		cmd_o.load   = 1'b0;
		cmd_o.rd_en  = 1'b0;
		cmd_o.commit = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd_o.load = 1'b1;
					state_d    = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd_o.rd_en = 1'b1;
				if (cnt_q == IW'(DEPTH - 1)) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_WRITE;
			end
			S_WRITE: begin
				// Wait until the output register is free or being emptied.
				if (!sts.out_busy) begin
					cmd_o.commit = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd_o.load) begin
				cnt_q <= '0;
			end else if (cmd_o.rd_en && cnt_q != IW'(DEPTH - 1)) begin
				cnt_q <= cnt_q + IW'(1);
			end
		end
	end

endmodule

FILE: rtl/ffsa_dp.sv
// ----------------------------------------------------------------------------
// ffsa_dp: allocator datapath
// Configuration, segment tables, scan evaluation, table updates and result.
// ----------------------------------------------------------------------------
module ffsa_dp
	import ffsa_pkg::*;
#(
	parameter int FREE_ENTRIES  = FREE_ENTRIES_DEF,
	parameter int ALLOC_ENTRIES = ALLOC_ENTRIES_DEF,
	localparam int DEPTH = (FREE_ENTRIES > ALLOC_ENTRIES) ? FREE_ENTRIES : ALLOC_ENTRIES,
	localparam int IW    = $clog2(DEPTH),
	localparam int FAW   = $clog2(FREE_ENTRIES),
	localparam int AAW   = $clog2(ALLOC_ENTRIES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [31:0]   cfg_data,
	input  logic          cmd,
	input  logic [31:0]   request_size,
	input  logic [31:0]   free_offset,
	input  ffsa_cmd_t     cmd_i,
	input  logic [IW-1:0] rd_idx,
	output ffsa_sts_t     sts,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [2:0]    status,
	output logic [31:0]   granted_offset,
	output logic [31:0]   granted_size
);

	// Configuration and table bookkeeping.
	logic [31:0]              region_size_q;
	logic [4:0]               align_shift_q;
	logic                     free_init_q;
	logic [FREE_ENTRIES-1:0]  free_valid_q;
	logic [ALLOC_ENTRIES-1:0] alloc_valid_q;

	// Item being worked on.
	logic        cmd_q;
	logic [32:0] seg_q;
	logic [31:0] foff_q;

	// Scan pipeline and search results.
	logic          rd_en_s1;
	logic [IW-1:0] idx_s1;
	logic          best_found_q, slot_found_q, hit_found_q;
	logic [FAW-1:0] best_idx_q;
	logic [31:0]   best_off_q, best_size_q;
	logic [IW-1:0] slot_q;
	logic [AAW-1:0] hit_idx_q;
	logic [31:0]   hit_off_q, hit_size_q;

	// Output register.
	logic        out_valid_q;
	status_t     status_q;
	logic [31:0] goff_q, gsize_q;

	// Aligned size of the incoming request.
	logic [4:0]  sh;
	logic [32:0] unit_m1;
	logic [31:0] req1;
	logic [32:0] seg_d;

	always_comb begin
		sh      = (align_shift_q > ALIGN_SHIFT_MAX) ? ALIGN_SHIFT_MAX : align_shift_q;
		unit_m1 = (33'd1 << sh) - 33'd1;
		req1    = (request_size == '0) ? 32'd1 : request_size;
		seg_d   = ({1'b0, req1} + unit_m1) & ~unit_m1;
	end

	// Table memories: offset in the upper half, size in the lower half.
	logic            free_we, alloc_we;
	logic [FAW-1:0]  free_waddr;
	logic [AAW-1:0]  alloc_waddr;
	logic [63:0]     free_wdata, alloc_wdata, free_rdata, alloc_rdata;
	logic            free_re, alloc_re;

	assign free_re  = cmd_i.rd_en && ({1'b0, rd_idx} < (IW + 1)'(FREE_ENTRIES));
	assign alloc_re = cmd_i.rd_en && ({1'b0, rd_idx} < (IW + 1)'(ALLOC_ENTRIES));

	ffsa_ram #(.WIDTH(64), .DEPTH(FREE_ENTRIES)) u_free_ram (
		.clk   (clk),
		.we    (free_we),
		.waddr (free_waddr),
		.wdata (free_wdata),
		.re    (free_re),
		.raddr (rd_idx[FAW-1:0]),
		.rdata (free_rdata)
	);

	ffsa_ram #(.WIDTH(64), .DEPTH(ALLOC_ENTRIES)) u_alloc_ram (
		.clk   (clk),
		.we    (alloc_we),
		.waddr (alloc_waddr),
		.wdata (alloc_wdata),
		.re    (alloc_re),
		.raddr (rd_idx[AAW-1:0]),
		.rdata (alloc_rdata)
	);

	// Evaluation of the entry read in the previous cycle.
	logic        f_in, a_in, f_vld, a_vld;
	logic [31:0] f_off, f_size, a_off, a_size;

	always_comb begin
		f_in  = ({1'b0, idx_s1} < (IW + 1)'(FREE_ENTRIES));
		a_in  = ({1'b0, idx_s1} < (IW + 1)'(ALLOC_ENTRIES));
		f_vld = f_in && free_valid_q[idx_s1[FAW-1:0]];
		a_vld = a_in && alloc_valid_q[idx_s1[AAW-1:0]];
		// Entry 0 reads as the whole region until it is first written.
		if (free_init_q && idx_s1 == '0) begin
			f_off  = '0;
			f_size = region_size_q;
		end else begin
			f_off  = free_rdata[63:32];
			f_size = free_rdata[31:0];
		end
		a_off  = alloc_rdata[63:32];
		a_size = alloc_rdata[31:0];
	end

	// Outcome of the finished scan.
	logic    ok, fits_part;
	status_t st;
	logic [31:0] seg32;

	assign seg32     = seg_q[31:0];
	assign fits_part = (best_size_q > seg32);

	always_comb begin
		ok = 1'b0;
		st = ST_OK;
		if (!cmd_q) begin
			if (seg_q[32]) begin
				st = ST_OVERFLOW;
			end else if (!best_found_q) begin
				st = ST_NOFIT;
			end else if (!slot_found_q) begin
				st = ST_FULL;
			end else begin
				ok = 1'b1;
			end
		end else begin
			if (!hit_found_q) begin
				st = ST_UNKNOWN;
			end else if (!slot_found_q) begin
				st = ST_FULL;
			end else begin
				ok = 1'b1;
			end
		end
	end

	always_comb begin
		free_we     = cmd_i.commit && ok && (cmd_q || fits_part);
		free_waddr  = cmd_q ? slot_q[FAW-1:0] : best_idx_q;
		free_wdata  = cmd_q ? {hit_off_q, hit_size_q}
		                    : {best_off_q + seg32, best_size_q - seg32};
		alloc_we    = cmd_i.commit && ok && !cmd_q;
		alloc_waddr = slot_q[AAW-1:0];
		alloc_wdata = {best_off_q, seg32};
	end

	// Configuration and valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_size_q <= REGION_SIZE_RST;
			align_shift_q <= ALIGN_SHIFT_RST;
			free_init_q   <= 1'b1;
			free_valid_q  <= FREE_ENTRIES'(1);
			alloc_valid_q <= '0;
		end else begin
			if (cfg_we && cfg_index == REG_REGION_SIZE) begin
				region_size_q <= cfg_data;
				free_init_q   <= 1'b1;
				free_valid_q  <= FREE_ENTRIES'(1);
				alloc_valid_q <= '0;
			end else if (cfg_we && cfg_index == REG_ALIGN_SHIFT) begin
				align_shift_q <= cfg_data[4:0];
			end else if (cmd_i.commit && ok) begin
				if (free_we && free_waddr == '0) begin
					free_init_q <= 1'b0;
				end
				if (cmd_q) begin
					free_valid_q[slot_q[FAW-1:0]] <= 1'b1;
					alloc_valid_q[hit_idx_q]      <= 1'b0;
				end else begin
					alloc_valid_q[slot_q[AAW-1:0]] <= 1'b1;
					if (!fits_part) begin
						free_valid_q[best_idx_q] <= 1'b0;
					end
				end
			end
		end
	end

	// Scan control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_en_s1     <= 1'b0;
			best_found_q <= 1'b0;
			slot_found_q <= 1'b0;
			hit_found_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_en_s1 <= cmd_i.rd_en;
			if (cmd_i.load) begin
				best_found_q <= 1'b0;
				slot_found_q <= 1'b0;
				hit_found_q  <= 1'b0;
			end else if (rd_en_s1) begin
				if (!cmd_q) begin
					if (f_vld && ({1'b0, f_size} >= seg_q) &&
					    (!best_found_q || f_off < best_off_q)) begin
						best_found_q <= 1'b1;
					end
					if (a_in && !a_vld) begin
						slot_found_q <= 1'b1;
					end
				end else begin
					if (a_vld && a_off == foff_q) begin
						hit_found_q <= 1'b1;
					end
					if (f_in && !f_vld) begin
						slot_found_q <= 1'b1;
					end
				end
			end
			if (cmd_i.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx;
		if (cmd_i.load) begin
			cmd_q  <= cmd;
			seg_q  <= seg_d;
			foff_q <= free_offset;
		end
		if (rd_en_s1) begin
			if (!cmd_q) begin
				if (f_vld && ({1'b0, f_size} >= seg_q) &&
				    (!best_found_q || f_off < best_off_q)) begin
					best_idx_q  <= idx_s1[FAW-1:0];
					best_off_q  <= f_off;
					best_size_q <= f_size;
				end
				if (a_in && !a_vld && !slot_found_q) begin
					slot_q <= idx_s1;
				end
			end else begin
				if (a_vld && a_off == foff_q && !hit_found_q) begin
					hit_idx_q  <= idx_s1[AAW-1:0];
					hit_off_q  <= a_off;
					hit_size_q <= a_size;
				end
				if (f_in && !f_vld && !slot_found_q) begin
					slot_q <= idx_s1;
				end
			end
		end
		if (cmd_i.commit) begin
			status_q <= st;
			goff_q   <= (ok && !cmd_q) ? best_off_q : '0;
			gsize_q  <= ok ? (cmd_q ? hit_size_q : seg32) : '0;
		end
	end

	assign sts.out_valid = out_valid_q;
	assign sts.out_busy  = out_valid_q && out_stall;

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign granted_offset = goff_q;
	assign granted_size   = gsize_q;

endmodule

FILE: rtl/first_fit_segment_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator: first-fit allocator over one memory region
// Allocates and frees aligned segments using a free table and an allocated
// table, each held in a RAM with per-entry valid bits.
// ----------------------------------------------------------------------------
// Every item, allocate or free, passes through the same steps: the item is
// accepted and its aligned size computed, both table RAMs are read through
// their single read ports, one table entry at a time, the registered read
// data is drained, and the table updates are committed and the result
// register loaded. One item is worked on at a time; a new item is accepted
// while the previous result still waits in the output register, and the
// commit of the new item waits until that result has been taken. An allocate
// rounds request_size up to a multiple of 2^align_shift bytes (a zero request
// counts as one byte, alignment above 16 counts as 16) and takes the valid
// free segment with the lowest offset that is large enough, shrinking it in
// place or dropping it on an exact fit. A free looks up the allocated segment
// by its offset and adds it back to the free table as a new segment, without
// merging neighbors. New entries go to the lowest-numbered unused slot.
// Writing region_size re-initializes both tables at once: the free table
// returns to one segment covering the whole region. Configuration is to be
// written only while no item is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator
	import ffsa_pkg::*;
#(
	parameter int FREE_ENTRIES  = FREE_ENTRIES_DEF,
	parameter int ALLOC_ENTRIES = ALLOC_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	// Input item channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [31:0] request_size,
	input  logic [31:0] free_offset,
	// Result item channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] granted_offset,
	output logic [31:0] granted_size
);

	localparam int DEPTH = (FREE_ENTRIES > ALLOC_ENTRIES) ? FREE_ENTRIES : ALLOC_ENTRIES;
	localparam int IW    = $clog2(DEPTH);

	ffsa_cmd_t     ctl_cmd;
	ffsa_sts_t     dp_sts;
	logic [IW-1:0] rd_idx;

	// The controller walks the scan index over both tables in lockstep.
	ffsa_ctrl #(
		.FREE_ENTRIES  (FREE_ENTRIES),
		.ALLOC_ENTRIES (ALLOC_ENTRIES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (dp_sts),
		.cmd_o    (ctl_cmd),
		.rd_idx   (rd_idx)
	);

	// The datapath holds the tables, the search results and the result register.
	ffsa_dp #(
		.FREE_ENTRIES  (FREE_ENTRIES),
		.ALLOC_ENTRIES (ALLOC_ENTRIES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.request_size   (request_size),
		.free_offset    (free_offset),
		.cmd_i          (ctl_cmd),
		.rd_idx         (rd_idx),
		.sts            (dp_sts),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.granted_offset (granted_offset),
		.granted_size   (granted_size)
	);

endmodule

FILE: sim/first_fit_segment_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_test: self-checking bench of the segment allocator
// Drives allocate and free items through the valid/stall channels. A model of
// the free and allocated tables predicts every result, and each result is
// compared field by field, in order. The run covers directed corner cases,
// fill-and-drain sequences that hit both table-full cases, random mixes under
// several region and alignment settings, and a long hold-off on the result
// side that backs the block up.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_test;
	import ffsa_pkg::*;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;
	localparam int   LIMIT_CYCLES = 1500000;

	// One expected result item.
	typedef struct packed {
		status_t     status;
		logic [31:0] offset;
		logic [31:0] size;
	} grant_t;

	// One table entry of the allocator model.
	typedef struct {
		bit          valid;
		logic [31:0] offset;
		logic [31:0] size;
	} segment_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        cmd;
	logic [31:0] request_size;
	logic [31:0] free_offset;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [31:0] granted_offset;
	logic [31:0] granted_size;

	// Model state: its own copy of the registers and of both tables.
	logic [31:0] region_bytes;
	logic [4:0]  align_log2;
	segment_t    free_segs[FREE_ENTRIES_DEF];
	segment_t    alloc_segs[ALLOC_ENTRIES_DEF];

	grant_t      pending_grants[$];
	int          mismatches;
	int          cycle_count;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          hold_cycles;

	first_fit_segment_allocator uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.request_size   (request_size),
		.free_offset    (free_offset),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.granted_offset (granted_offset),
		.granted_size   (granted_size)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A hard ceiling on the run, far above the slowest legal run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("first_fit_segment_allocator verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Allocator model
	// ------------------------------------------------------------------

	// The free table restarts as one segment over the whole region, and the
	// allocated table restarts empty.
	function automatic void clear_segment_tables();
		foreach (free_segs[i])
			free_segs[i] = '{1'b0, 32'd0, 32'd0};
		foreach (alloc_segs[i])
			alloc_segs[i] = '{1'b0, 32'd0, 32'd0};
		free_segs[0] = '{1'b1, 32'd0, region_bytes};
	endfunction

	// Works out the result of one item and applies its effect on the tables.
	function automatic grant_t predict_grant(input logic op, input logic [31:0] req,
			input logic [31:0] off);
		grant_t      g;
		logic [63:0] unit;
		logic [63:0] seg;
		logic [4:0]  shift;
		int          best;
		int          slot;
		int          hit;
		g = '{ST_OK, 32'd0, 32'd0};
		best = -1;
		slot = -1;
		hit = -1;
		if (op == CMD_ALLOC) begin
			// Alignment beyond 16 is clamped, and a zero request counts as one byte.
			shift = (align_log2 > ALIGN_SHIFT_MAX) ? ALIGN_SHIFT_MAX : align_log2;
			unit = 64'd1 << shift;
			seg = (req == 32'd0) ? 64'd1 : {32'd0, req};
			seg = (seg + unit - 64'd1) & ~(unit - 64'd1);
			if (seg[63:32] != 32'd0) begin
				g.status = ST_OVERFLOW;
				return g;
			end
			// First fit means the lowest offset, not the lowest table index.
			for (int i = 0; i < FREE_ENTRIES_DEF; i++) begin
				if (free_segs[i].valid && free_segs[i].size >= seg[31:0] &&
						(best < 0 || free_segs[i].offset < free_segs[best].offset))
					best = i;
			end
			if (best < 0) begin
				g.status = ST_NOFIT;
				return g;
			end
			for (int i = 0; i < ALLOC_ENTRIES_DEF && slot < 0; i++) begin
				if (!alloc_segs[i].valid)
					slot = i;
			end
			if (slot < 0) begin
				g.status = ST_FULL;
				return g;
			end
			alloc_segs[slot] = '{1'b1, free_segs[best].offset, seg[31:0]};
			g.offset = free_segs[best].offset;
			g.size = seg[31:0];
			// Shrink the chosen segment in place, or drop it on an exact fit.
			if (free_segs[best].size > seg[31:0]) begin
				free_segs[best].offset = free_segs[best].offset + seg[31:0];
				free_segs[best].size = free_segs[best].size - seg[31:0];
			end else begin
				free_segs[best].valid = 1'b0;
			end
		end else begin
			for (int i = 0; i < ALLOC_ENTRIES_DEF && hit < 0; i++) begin
				if (alloc_segs[i].valid && alloc_segs[i].offset == off)
					hit = i;
			end
			if (hit < 0) begin
				g.status = ST_UNKNOWN;
				return g;
			end
			for (int i = 0; i < FREE_ENTRIES_DEF && slot < 0; i++) begin
				if (!free_segs[i].valid)
					slot = i;
			end
			// With no room in the free table the segment stays allocated.
			if (slot < 0) begin
				g.status = ST_FULL;
				return g;
			end
			free_segs[slot] = '{1'b1, alloc_segs[hit].offset, alloc_segs[hit].size};
			alloc_segs[hit].valid = 1'b0;
			g.size = alloc_segs[hit].size;
		end
		return g;
	endfunction

	function automatic int live_alloc_count();
		int n;
		n = 0;
		foreach (alloc_segs[i])
			if (alloc_segs[i].valid)
				n++;
		return n;
	endfunction

	// Offset of a random live allocation, or a random offset when none is live.
	function automatic logic [31:0] pick_live_offset();
		int n;
		int k;
		n = live_alloc_count();
		if (n == 0)
			return $urandom;
		k = $urandom_range(0, n - 1);
		foreach (alloc_segs[i]) begin
			if (alloc_segs[i].valid) begin
				if (k == 0)
					return alloc_segs[i].offset;
				k--;
			end
		end
		return $urandom;
	endfunction

	// Size of a random free segment, so that exact fits come up often.
	function automatic logic [31:0] pick_free_size();
		int n;
		int k;
		n = 0;
		foreach (free_segs[i])
			if (free_segs[i].valid)
				n++;
		if (n == 0)
			return $urandom;
		k = $urandom_range(0, n - 1);
		foreach (free_segs[i]) begin
			if (free_segs[i].valid) begin
				if (k == 0)
					return free_segs[i].size;
				k--;
			end
		end
		return $urandom;
	endfunction

	// Mostly sizes that are small against the region, with zero, exact fits,
	// full-range values and values that overflow once aligned mixed in.
	function automatic logic [31:0] pick_request_size();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return $urandom;
			2: return pick_free_size();
			3: return 32'hFFFF_FFFF - $urandom_range(0, 65535);
			default: return $urandom_range(0, region_bytes >> $urandom_range(5, 9));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Channel drivers and result checker
	// ------------------------------------------------------------------

	// Offers one item, holds it until the block takes it, then records the
	// expected result. Inputs move only on the falling edge.
	task automatic send_item(input logic op, input logic [31:0] req,
			input logic [31:0] off);
		grant_t expected;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		cmd = op;
		request_size = req;
		free_offset = off;
		do
			@(posedge clk);
		while (in_stall);
		expected = predict_grant(op, req, off);
		pending_grants = {pending_grants, expected};
	endtask

	// Stops offering items and waits until every expected result is back.
	task automatic quiesce();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
	endtask

	// Register writes happen only with the block idle. Writing the region size
	// restarts both tables, in the block and in the model alike.
	task automatic write_reg(input logic idx, input logic [31:0] value);
		quiesce();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		cfg_data = $urandom;
		if (idx == REG_REGION_SIZE) begin
			region_bytes = value;
			clear_segment_tables();
		end else begin
			align_log2 = value[4:0];
		end
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at cycle %0d: %s is %h, expected %h", cycle_count, field,
			got, want);
		mismatches++;
	endtask

	// The receiver stalls at random, or for a counted stretch when a hold-off
	// has been requested.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall = 1'b1;
			hold_cycles--;
		end else begin
			out_stall = ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Every result taken is matched against the oldest expectation.
	always @(posedge clk) begin
		grant_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_grants.size() == 0) begin
				report_mismatch("unexpected result status", {29'd0, status}, 32'd0);
			end else begin
				want = pending_grants.pop_front();
				if (status !== want.status)
					report_mismatch("status", {29'd0, status}, {29'd0, want.status});
				if (granted_offset !== want.offset)
					report_mismatch("granted_offset", granted_offset, want.offset);
				if (granted_size !== want.size)
					report_mismatch("granted_size", granted_size, want.size);
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset settings: both commands, reuse of a freed hole at the lowest
	// offset, an aligned size that overflows, a request beyond the region and
	// a free of an offset that was never handed out.
	task automatic test_basic_ops();
		send_item(CMD_ALLOC, 32'd0, 32'hFFFF_FFFF);
		send_item(CMD_ALLOC, 32'd1, 32'd0);
		send_item(CMD_ALLOC, 32'hFFFF_FFFF, 32'd0);
		send_item(CMD_ALLOC, REGION_SIZE_RST, 32'd0);
		send_item(CMD_FREE, 32'hFFFF_FFFF, 32'd12345);
		send_item(CMD_FREE, 32'd0, 32'd0);
		send_item(CMD_ALLOC, 32'd100, 32'd0);
		send_item(CMD_ALLOC, 32'd300, 32'd0);
	endtask

	// Register extremes: the largest region taken whole, an empty free table,
	// alignment of zero, of sixteen and above sixteen, and a one-byte region.
	task automatic test_config_limits();
		write_reg(REG_ALIGN_SHIFT, 32'd0);
		write_reg(REG_REGION_SIZE, 32'hFFFF_FFFF);
		send_item(CMD_ALLOC, 32'hFFFF_FFFF, 32'd0);
		send_item(CMD_ALLOC, 32'd0, 32'd0);
		send_item(CMD_FREE, 32'd0, 32'd0);
		send_item(CMD_FREE, 32'd0, 32'hFFFF_FFFF);
		write_reg(REG_ALIGN_SHIFT, 32'd31);
		send_item(CMD_ALLOC, 32'd1, 32'd0);
		send_item(CMD_ALLOC, 32'hFFFF_0001, 32'd0);
		send_item(CMD_ALLOC, 32'hFFFF_0000, 32'd0);
		write_reg(REG_REGION_SIZE, 32'd1);
		write_reg(REG_ALIGN_SHIFT, 32'd0);
		send_item(CMD_ALLOC, 32'd0, 32'd0);
		send_item(CMD_ALLOC, 32'd0, 32'd0);
		write_reg(REG_ALIGN_SHIFT, {27'd0, ALIGN_SHIFT_MAX});
		send_item(CMD_FREE, 32'd0, 32'd0);
		send_item(CMD_ALLOC, 32'd0, 32'd0);
	endtask

	// Allocates until the allocated table is full and once more, then frees
	// every live segment in random order. Since neighbors never merge, the
	// frees fill the free table and the last one finds it full.
	task automatic test_fill_and_drain(input logic [31:0] region, input logic [4:0] shift);
		int tries;
		write_reg(REG_REGION_SIZE, region);
		write_reg(REG_ALIGN_SHIFT, {27'd0, shift});
		tries = 0;
		while (live_alloc_count() < ALLOC_ENTRIES_DEF && tries < 80) begin
			send_item(CMD_ALLOC, $urandom_range(0, region >> 8), $urandom);
			tries++;
		end
		send_item(CMD_ALLOC, $urandom_range(0, region >> 8), $urandom);
		tries = live_alloc_count() + 2;
		repeat (tries)
			send_item(CMD_FREE, $urandom, pick_live_offset());
	endtask

	// Random allocates and frees. Most frees name a live segment; the rest
	// name random offsets or offsets just off a live one.
	task automatic test_random_mix(input logic [31:0] region, input logic [4:0] shift,
			input int count);
		int r;
		write_reg(REG_REGION_SIZE, region);
		write_reg(REG_ALIGN_SHIFT, {27'd0, shift});
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 50)
				send_item(CMD_ALLOC, pick_request_size(), $urandom);
			else if (r < 85)
				send_item(CMD_FREE, $urandom, pick_live_offset());
			else if (r < 93)
				send_item(CMD_FREE, $urandom, $urandom);
			else
				send_item(CMD_FREE, $urandom, pick_live_offset() + 32'd1);
		end
	endtask

	// The receiver holds off for a long stretch while items keep coming, so
	// the output register fills, the next item waits for its commit and the
	// block finally stalls its input.
	task automatic test_back_pressure();
		write_reg(REG_REGION_SIZE, REGION_SIZE_RST);
		write_reg(REG_ALIGN_SHIFT, {27'd0, ALIGN_SHIFT_RST});
		@(posedge clk);
		hold_cycles = 600;
		repeat (8)
			send_item(CMD_ALLOC, $urandom_range(0, 4096), $urandom);
		repeat (3)
			send_item(CMD_FREE, $urandom, pick_live_offset());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_REGION_SIZE;
		cfg_data = 32'd0;
		in_valid = 1'b0;
		cmd = CMD_ALLOC;
		request_size = 32'd0;
		free_offset = 32'd0;
		out_stall = 1'b0;
		mismatches = 0;
		cycle_count = 0;
		hold_cycles = 0;
		send_idle_pct = 15;
		recv_idle_pct = 71;
		region_bytes = REGION_SIZE_RST;
		align_log2 = ALIGN_SHIFT_RST;
		clear_segment_tables();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_basic_ops();
		test_config_limits();

		// Three idling patterns: a slow receiver, then a slow sender, then
		// neither side idling.
		for (int mode = 0; mode < 3; mode++) begin
			quiesce();
			@(posedge clk);
			send_idle_pct = (mode == 0) ? 15 : (mode == 1) ? 71 : 0;
			recv_idle_pct = (mode == 0) ? 71 : (mode == 1) ? 15 : 0;
			test_fill_and_drain($urandom_range(32'h0010_0000, 32'hFFFF_FFFF),
				$urandom_range(0, 12));
			case (mode)
				0: test_random_mix($urandom, $urandom_range(0, 31), 450);
				1: test_random_mix($urandom_range(1, 4096), $urandom_range(0, 4), 450);
				default: test_random_mix(REGION_SIZE_RST, $urandom_range(0, 16), 450);
			endcase
			if (mode == 0)
				test_back_pressure();
		end

		// Drain, then leave room for any stray result to show up.
		quiesce();
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("first_fit_segment_allocator verification clean");
		else
			$display("first_fit_segment_allocator verification failed");
		$finish;
	end

endmodule
